// ===== rtl/fpesc_pkg.sv =====
// Package for the frustum plane extract and sphere cull block.
// Command codes, plane table and default number format; no dependencies.
`default_nettype none

package fpesc_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] OP_LOAD_PROJ = 2'd0;
  localparam logic [1:0] OP_LOAD_MV   = 2'd1;
  localparam logic [1:0] OP_EXTRACT   = 2'd2;
  localparam logic [1:0] OP_TEST      = 2'd3;

  localparam int NUM_PLANES = 6;

  // Plane p subtracts column p/2 from column 3 when bit p is set
  // (right, left, bottom, top, far, near).
  localparam logic [NUM_PLANES-1:0] PLANE_NEG = 6'b011001;

  localparam logic [2:0] CULL_NONE = 3'd6;

endpackage

`default_nettype wire

// ===== rtl/frustum_plane_extract_sphere_cull.sv =====
// Frustum plane extraction from projection and modelview, and sphere test.
// Matrix element writes complete in idle. A sphere test raises res_valid with cmd_ready
// back in the same cycle, so one test runs at a time; extract time (default format Q16.16)
// is set by the shared multiplier, the bit-serial square root and the bit-serial divider.
// Reset clears the sequencer, res_valid and the plane valid bits (all planes read zero).
// Depends on fpesc_pkg.
`default_nettype none

module frustum_plane_extract_sphere_cull
  import fpesc_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire logic [1:0]         op,
  input  wire logic [3:0]         elem_index,
  input  wire logic signed [31:0] elem_value,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] center_z,
  input  wire logic [30:0]        sphere_radius,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic                    visible,
  output logic [2:0]              cull_plane
);

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = (W > 32) ? W : 32;   // multiplier operand width
  localparam int PW  = 2 * MW;              // product width
  localparam int ACW = 64;                  // accumulator width
  localparam int TW  = 60;                  // floored, clamped product width
  localparam int SSW = 2 * W;               // sum of squares
  localparam int LW  = W;                   // normal length
  localparam int RW  = LW + 2;              // sqrt remainder
  localparam int NW  = W + F;               // dividend / quotient
  localparam int CW  = $clog2(NW);

  localparam logic signed [ACW-1:0] VMAX_A = $signed((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [ACW-1:0] VMIN_A = -VMAX_A - 64'sd1;
  localparam logic signed [W-1:0]   VMAX_W = VMAX_A[W-1:0];
  localparam logic signed [W-1:0]   VMIN_W = VMIN_A[W-1:0];
  localparam logic signed [PW-1:0]  TMAX_P = $signed((PW'(1) << (TW - 1)) - PW'(1));
  localparam logic signed [PW-1:0]  TMIN_P = -TMAX_P - PW'(1);
  localparam logic [NW-1:0]         VMAXU_N = (NW'(1) << (W - 1)) - NW'(1);
  localparam logic [4:0]            TC_END = 5'(NUM_PLANES * 4);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;   // clip: read matrix pair
  localparam logic [3:0] S_CMUL  = 4'd2;   // clip: multiply
  localparam logic [3:0] S_CACC  = 4'd3;   // clip: accumulate / store
  localparam logic [3:0] S_PRD   = 4'd4;   // plane: read clip pair
  localparam logic [3:0] S_PV    = 4'd5;   // plane: column add/sub
  localparam logic [3:0] S_SQ    = 4'd6;   // plane: square
  localparam logic [3:0] S_SQA   = 4'd7;   // plane: sum squares
  localparam logic [3:0] S_SQRT  = 4'd8;   // plane: one root bit per cycle
  localparam logic [3:0] S_DIV   = 4'd9;   // plane: one quotient bit per cycle
  localparam logic [3:0] S_PZERO = 4'd10;  // plane: zero-length normal
  localparam logic [3:0] S_TEST  = 4'd11;  // sphere: pipelined dot products
  localparam logic [3:0] S_HOLD  = 4'd12;  // sphere: post result

  function automatic logic signed [W-1:0] sat_w(input logic signed [ACW-1:0] x);
    if (x > VMAX_A) sat_w = VMAX_W;
    else if (x < VMIN_A) sat_w = VMIN_W;
    else sat_w = x[W-1:0];
  endfunction

  // floor shift by F, clamp to signed 60 bits
  function automatic logic signed [TW-1:0] sat_t(input logic signed [PW-1:0] pr);
    logic signed [PW-1:0] s;
    s = pr >>> F;
    if (s > TMAX_P) sat_t = TMAX_P[TW-1:0];
    else if (s < TMIN_P) sat_t = TMIN_P[TW-1:0];
    else sat_t = s[TW-1:0];
  endfunction

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    mag_w = v[W-1] ? W'(~v + 1'b1) : v;
  endfunction

  // storage
  logic signed [W-1:0] pj_mem   [16];
  logic signed [W-1:0] mv_mem   [16];
  logic signed [W-1:0] clip_mem [16];
  logic signed [W-1:0] pl_mem   [24];
  logic [NUM_PLANES-1:0] pvalid;

  logic [3:0]            state;
  logic [3:0]            e;
  logic [1:0]            k;
  logic [2:0]            p;
  logic [1:0]            j;
  logic [CW-1:0]         cnt;
  logic signed [ACW-1:0] acc;
  logic signed [PW-1:0]  prod;
  logic signed [W-1:0]   mv_rd, pj_rd, ca_rd, cb_rd, pl_rd;
  logic signed [W-1:0]   vreg [4];
  logic [SSW-1:0]        ss, sq_val;
  logic [RW-1:0]         sq_rem;
  logic [LW-1:0]         sq_root, len;
  logic [NW-1:0]         dv_num, dv_q;
  logic [LW-1:0]         dv_rem;
  logic [4:0]            tc;
  logic                  s1_vld, s2_vld;
  logic [1:0]            s1_j, s2_j;
  logic [2:0]            s1_p, s2_p;
  logic signed [W-1:0]   s2_d;
  logic signed [31:0]    cx, cy, cz;
  logic [30:0]           rad;
  logic                  found;
  logic [2:0]            fplane;

  // shared multiplier operands
  logic signed [MW-1:0]  mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CMUL: begin
        mul_a = MW'(mv_rd);
        mul_b = MW'(pj_rd);
      end
      S_SQ: begin
        mul_a = MW'(vreg[j]);
        mul_b = MW'(vreg[j]);
      end
      S_TEST: begin
        mul_a = MW'(pl_rd);
        case (s1_j)
          2'd0:    mul_b = MW'(cx);
          2'd1:    mul_b = MW'(cy);
          2'd2:    mul_b = MW'(cz);
          default: mul_b = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath arithmetic
  logic signed [ACW-1:0] acc_c, pv_sum, term2, acc_t, radn;
  logic                  cull;
  logic [SSW-1:0]        ss_n;
  logic [RW+1:0]         sq_sh, sq_trial;
  logic                  sq_ge;
  logic [RW-1:0]         sq_rem_n;
  logic [LW-1:0]         sq_root_n;
  logic [LW:0]           dv_sh;
  logic                  dv_ge;
  logic [LW-1:0]         dv_rem_n;
  logic [NW-1:0]         dv_q_n;
  logic                  coef_big;
  logic [W-1:0]          qlo;
  logic signed [W-1:0]   coef;

  always_comb begin
    acc_c  = acc + ACW'(sat_t(prod));
    pv_sum = PLANE_NEG[p] ? (ACW'(ca_rd) - ACW'(cb_rd)) : (ACW'(ca_rd) + ACW'(cb_rd));
    ss_n   = ss + prod[SSW-1:0];

    sq_sh     = {sq_rem, sq_val[SSW-1:SSW-2]};
    sq_trial  = (RW + 2)'({sq_root, 2'b01});
    sq_ge     = sq_sh >= sq_trial;
    sq_rem_n  = RW'(sq_ge ? (sq_sh - sq_trial) : sq_sh);
    sq_root_n = {sq_root[LW-2:0], sq_ge};

    dv_sh    = {dv_rem, dv_num[NW-1]};
    dv_ge    = dv_sh >= {1'b0, len};
    dv_rem_n = LW'(dv_ge ? (dv_sh - {1'b0, len}) : dv_sh);
    dv_q_n   = {dv_q[NW-2:0], dv_ge};

    // magnitude quotient back to signed, clamped
    coef_big = dv_q_n > VMAXU_N;
    qlo      = dv_q_n[W-1:0];
    if (vreg[j][W-1]) coef = coef_big ? VMIN_W : $signed(W'(~qlo + 1'b1));
    else              coef = coef_big ? VMAX_W : $signed(qlo);

    term2 = (s2_j == 2'd3) ? ACW'(s2_d) : ACW'(sat_t(prod));
    acc_t = ((s2_j == 2'd0) ? ACW'(0) : acc) + term2;
    radn  = -$signed(ACW'(rad));
    cull  = acc_t <= radn;
  end

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pvalid    <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
    end else begin
      s1_vld <= (state == S_TEST) && (tc != TC_END);
      s2_vld <= s1_vld;
      s1_j   <= tc[1:0];
      s1_p   <= tc[4:2];
      s2_j   <= s1_j;
      s2_p   <= s1_p;
      s2_d   <= pl_rd;
      if (res_valid && res_ready) res_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (op)
              OP_LOAD_PROJ: pj_mem[elem_index] <= sat_w(ACW'(elem_value));
              OP_LOAD_MV:   mv_mem[elem_index] <= sat_w(ACW'(elem_value));
              OP_EXTRACT: begin
                e     <= '0;
                k     <= '0;
                acc   <= '0;
                state <= S_CRD;
              end
              OP_TEST: begin
                cx     <= center_x;
                cy     <= center_y;
                cz     <= center_z;
                rad    <= sphere_radius;
                tc     <= '0;
                found  <= 1'b0;
                fplane <= '0;
                state  <= S_TEST;
              end
              default: ;
            endcase
          end
        end

        S_CRD: begin
          mv_rd <= mv_mem[{e[3:2], k}];
          pj_rd <= pj_mem[{k, e[1:0]}];
          state <= S_CMUL;
        end

        S_CMUL: state <= S_CACC;

        S_CACC: begin
          if (k == 2'd3) begin
            clip_mem[e] <= sat_w(acc_c);
            acc <= '0;
            k   <= '0;
            if (e == 4'd15) begin
              p     <= '0;
              j     <= '0;
              state <= S_PRD;
            end else begin
              e     <= e + 4'd1;
              state <= S_CRD;
            end
          end else begin
            acc   <= acc_c;
            k     <= k + 2'd1;
            state <= S_CRD;
          end
        end

        S_PRD: begin
          ca_rd <= clip_mem[{j, 2'd3}];
          cb_rd <= clip_mem[{j, p[2:1]}];
          state <= S_PV;
        end

        S_PV: begin
          vreg[j] <= sat_w(pv_sum);
          if (j == 2'd3) begin
            j     <= '0;
            ss    <= '0;
            state <= S_SQ;
          end else begin
            j     <= j + 2'd1;
            state <= S_PRD;
          end
        end

        S_SQ: state <= S_SQA;

        S_SQA: begin
          if (j == 2'd2) begin
            sq_val  <= ss_n;
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
            j       <= '0;
            state   <= S_SQRT;
          end else begin
            ss    <= ss_n;
            j     <= j + 2'd1;
            state <= S_SQ;
          end
        end

        S_SQRT: begin
          sq_val  <= {sq_val[SSW-3:0], 2'b00};
          sq_rem  <= sq_rem_n;
          sq_root <= sq_root_n;
          cnt     <= cnt + 1'b1;
          if (cnt == CW'(LW - 1)) begin
            len <= sq_root_n;
            if (sq_root_n == '0) begin
              state <= S_PZERO;
            end else begin
              dv_num <= {mag_w(vreg[0]), {F{1'b0}}};
              dv_rem <= '0;
              dv_q   <= '0;
              cnt    <= '0;
              state  <= S_DIV;
            end
          end
        end

        S_DIV: begin
          dv_num <= {dv_num[NW-2:0], 1'b0};
          dv_rem <= dv_rem_n;
          dv_q   <= dv_q_n;
          cnt    <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) begin
            pl_mem[{p, j}] <= coef;
            cnt    <= '0;
            dv_rem <= '0;
            dv_q   <= '0;
            if (j == 2'd3) begin
              pvalid[p] <= 1'b1;
              j <= '0;
              if (p == 3'(NUM_PLANES - 1)) state <= S_IDLE;
              else begin
                p     <= p + 3'd1;
                state <= S_PRD;
              end
            end else begin
              dv_num <= {mag_w(vreg[j + 2'd1]), {F{1'b0}}};
              j      <= j + 2'd1;
            end
          end
        end

        S_PZERO: begin
          pl_mem[{p, j}] <= '0;
          if (j == 2'd3) begin
            pvalid[p] <= 1'b1;
            j <= '0;
            if (p == 3'(NUM_PLANES - 1)) state <= S_IDLE;
            else begin
              p     <= p + 3'd1;
              state <= S_PRD;
            end
          end else begin
            j <= j + 2'd1;
          end
        end

        S_TEST: begin
          // issue one coefficient read per cycle; planes never built read zero
          if (tc != TC_END) begin
            pl_rd <= pvalid[tc[4:2]] ? pl_mem[tc] : '0;
            tc    <= tc + 5'd1;
          end
          if (s2_vld) begin
            acc <= acc_t;
            if ((s2_j == 2'd3) && cull && !found) begin
              found  <= 1'b1;
              fplane <= s2_p;
            end
            if ((s2_j == 2'd3) && (s2_p == 3'(NUM_PLANES - 1))) state <= S_HOLD;
          end
        end

        S_HOLD: begin
          if (!res_valid || res_ready) begin
            res_valid  <= 1'b1;
            visible    <= !found;
            cull_plane <= found ? fplane : CULL_NONE;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fpesc_chk.sv =====
// Port-level checker for frustum_plane_extract_sphere_cull, with its bind.
// Depends on fpesc_pkg.
`default_nettype none

module fpesc_chk
  import fpesc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cmd_valid,
  input wire logic       cmd_ready,
  input wire logic [1:0] op,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       visible,
  input wire logic [2:0] cull_plane
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(visible) && $stable(cull_plane))
    else $error("result word changed while stalled");

  a_vis_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (visible == (cull_plane == CULL_NONE)))
    else $error("visible disagrees with cull_plane");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (cull_plane <= CULL_NONE))
    else $error("cull_plane out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (op == OP_TEST || op == OP_EXTRACT) |=> !cmd_ready)
    else $error("ready while a long command runs");

endmodule

bind frustum_plane_extract_sphere_cull fpesc_chk u_fpesc_chk (
  .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .op(op),
  .res_valid(res_valid), .res_ready(res_ready), .visible(visible),
  .cull_plane(cull_plane)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for frustum_plane_extract_sphere_cull: matrix loads, plane
// extraction and sphere tests, checked against an in-bench fixed-point predictor.
// Depends on fpesc_pkg and the RTL top level.
`default_nettype none

module testbench;
  import fpesc_pkg::*;

  localparam int  FB        = FRAC_BITS_DEF;
  localparam int  WD_LIMIT  = 20000;  // idle cycles; covers an extract plus the long hold-off
  localparam longint VMAX   = 64'sd2147483647;
  localparam longint VMIN   = -64'sd2147483648;

  // one command word as offered on the input channel
  typedef struct {
    logic [1:0]         op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        rad;
    bit                 drain;  // sender waits for all results before offering it
  } cmd_t;

  typedef struct {
    logic       vis;
    logic [2:0] plane;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  logic [1:0]         op = OP_LOAD_PROJ;
  logic [3:0]         elem_index = '0;
  logic signed [31:0] elem_value = '0;
  logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
  logic [30:0]        sphere_radius = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic               visible;
  logic [2:0]         cull_plane;

  frustum_plane_extract_sphere_cull dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .op(op), .elem_index(elem_index), .elem_value(elem_value),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .sphere_radius(sphere_radius),
    .res_valid(res_valid), .res_ready(res_ready),
    .visible(visible), .cull_plane(cull_plane)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: both matrices and the 6x4 plane table (a b c d per plane)
  // ---------------------------------------------------------------------------
  longint proj_m [16];
  longint mv_m [16];
  longint frustum_plane [24];

  cmd_t     pending_q [$];
  verdict_t verdict_q [$];

  int n_errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_culled = 0;
  int n_extracts = 0;

  function automatic longint sat_q(longint v);
    return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
  endfunction

  // exact product, floor shift; operands fit 32 bits so longint holds it
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] n);
    longint unsigned r, cand;
    logic [127:0] sq;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      sq = 128'(cand);
      sq = sq * sq;
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  function automatic longint qnorm(longint v, longint unsigned len);
    longint unsigned m, q;
    m = v < 0 ? -v : v;
    q = (m << FB) / len;
    if (v < 0) return q > VMAX ? VMIN : -longint'(q);
    return q > VMAX ? VMAX : longint'(q);
  endfunction

  task automatic rebuild_planes();
    longint clip [16];
    longint acc, pv [4], base, oth;
    logic [127:0] ss, t;
    longint unsigned len;
    int col;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += qmul(mv_m[r*4+k], proj_m[k*4+c]);
        clip[r*4+c] = sat_q(acc);
      end
    for (int p = 0; p < NUM_PLANES; p++) begin
      col = p / 2;
      ss = '0;
      for (int j = 0; j < 4; j++) begin
        base = clip[j*4+3];
        oth = clip[j*4+col];
        pv[j] = sat_q(PLANE_NEG[p] ? base - oth : base + oth);
      end
      for (int j = 0; j < 3; j++) begin
        t = 128'(pv[j] < 0 ? -pv[j] : pv[j]);
        ss += t * t;
      end
      len = isqrt(ss);
      // zero-length normal: plane stays all zero and culls only a sphere of radius zero
      for (int j = 0; j < 4; j++) frustum_plane[p*4+j] = len == 0 ? 0 : qnorm(pv[j], len);
    end
  endtask

  task automatic apply_cmd(cmd_t c);
    verdict_t v;
    longint dot;
    case (c.op)
      OP_LOAD_PROJ: proj_m[c.idx] = sat_q(longint'(c.val));
      OP_LOAD_MV:   mv_m[c.idx] = sat_q(longint'(c.val));
      OP_EXTRACT:   rebuild_planes();
      OP_TEST: begin
        v.vis = 1'b1;
        v.plane = CULL_NONE;
        for (int p = NUM_PLANES - 1; p >= 0; p--) begin
          dot = qmul(frustum_plane[p*4], c.cx) + qmul(frustum_plane[p*4+1], c.cy)
              + qmul(frustum_plane[p*4+2], c.cz) + frustum_plane[p*4+3];
          if (dot <= -longint'(c.rad)) begin
            v.vis = 1'b0;
            v.plane = 3'(p);
          end
        end
        verdict_q.push_back(v);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] pick_elem(int kind, int i, bit is_proj);
    int u;
    case (kind)
      0: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);   // about +-4.0
      1: begin
        // perspective-ish projection, rigid-ish modelview, small jitter
        u = $urandom_range(0, 1 << 12) - (1 << 11);
        if (is_proj && i == 11) return -32'sd65536 + u;
        if (is_proj && i == 14) return -32'sd131072 + u;
        if (!is_proj && i >= 12 && i < 15) return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        if (i % 5 == 0 && !(is_proj && i == 15)) return 32'sd65536 + u;
        return u;
      end
      2: begin
        u = $urandom_range(0, 3);
        return u == 0 ? 32'sh7fffffff : u == 1 ? 32'sh80000000 : u == 2 ? 32'sd0 : $urandom;
      end
      default: return '0;   // zero matrices: zero-length normals
    endcase
  endfunction

  function automatic cmd_t noise_cmd(logic [1:0] o);
    cmd_t c;
    c.op = o;
    c.idx = 4'($urandom);
    c.val = $urandom;
    c.cx = $urandom;
    c.cy = $urandom;
    c.cz = $urandom;
    c.rad = 31'($urandom);
    c.drain = 0;
    return c;
  endfunction

  function automatic cmd_t sphere_cmd(int span);
    cmd_t c;
    int r;
    c = noise_cmd(OP_TEST);
    if (span < 31) begin
      c.cx = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
      c.cy = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
      c.cz = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
    end
    r = $urandom_range(0, 9);
    if (r == 0) c.rad = '0;
    else if (r == 1) c.rad = 31'h7fffffff;
    else if (r < 8) c.rad = 31'($urandom_range(0, 1 << 18));
    return c;
  endfunction

  task automatic build_stimulus();
    cmd_t c;
    int kind, ntest, span;
    // planes read zero after reset: with extreme centers, a sphere is culled only at radius zero
    c = sphere_cmd(31);
    c.cx = 32'sh7fffffff; c.cy = 32'sh80000000; c.cz = 32'sh7fffffff; c.rad = '0;
    pending_q.push_back(c);
    c.cx = 32'sh80000000; c.cy = 32'sh7fffffff; c.cz = 32'sh80000000; c.rad = 31'h7fffffff;
    pending_q.push_back(c);
    pending_q.push_back(sphere_cmd(20));
    for (int s = 0; s < 20; s++) begin
      kind = s < 4 ? s : ($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
      // the first scene writes every element so no unwritten entry is ever read
      for (int i = 0; i < 16; i++) begin
        if (s == 0 || kind == 3 || $urandom_range(0, 2) != 0) begin
          c = noise_cmd(OP_LOAD_PROJ);
          c.idx = 4'(i);
          c.val = pick_elem(kind, i, 1);
          pending_q.push_back(c);
        end
        if (s == 0 || kind == 3 || $urandom_range(0, 2) != 0) begin
          c = noise_cmd(OP_LOAD_MV);
          c.idx = 4'(i);
          c.val = pick_elem(kind, i, 0);
          pending_q.push_back(c);
        end
      end
      pending_q.push_back(noise_cmd(OP_EXTRACT));
      if (s == 10) pending_q.push_back(noise_cmd(OP_EXTRACT));   // extract as matrices stand
      ntest = $urandom_range(58, 88);
      for (int t = 0; t < ntest; t++) begin
        span = $urandom_range(0, 9) == 0 ? 31 : $urandom_range(16, 22);
        c = sphere_cmd(span);
        if (s == 7 && t == 20) c.drain = 1;
        pending_q.push_back(c);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one command word per handshake, random gaps between words
  // ---------------------------------------------------------------------------
  int gap_cnt = 0;

  always @(posedge clk) begin
    cmd_t nxt;
    bit   take;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      take = cmd_valid && cmd_ready;
      if (take) begin
        apply_cmd(pending_q.pop_front());
        n_sent++;
        if (op == OP_EXTRACT) n_extracts++;
        // every fourth stretch of 150 words runs back to back
        gap_cnt = ((n_sent / 150) % 4 == 2) ? 0 : $urandom_range(0, 8);
      end
      if (!cmd_valid || take) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          cmd_valid <= 1'b0;
        end else if (pending_q.size() > 0 && (!pending_q[0].drain || verdict_q.size() == 0)) begin
          nxt = pending_q[0];
          cmd_valid <= 1'b1;
          op <= nxt.op;
          elem_index <= nxt.idx;
          elem_value <= nxt.val;
          center_x <= nxt.cx;
          center_y <= nxt.cy;
          center_z <= nxt.cz;
          sphere_radius <= nxt.rad;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, one long hold-off, in-order compare
  // ---------------------------------------------------------------------------
  int stall_cnt = 0;
  bit long_hold_done = 0;

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected: visible %0d plane %0d",
                   $time, visible, cull_plane);
          n_errors++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (visible !== exp_v.vis) begin
            $display("%0t: visible mismatch: expected %0d actual %0d",
                     $time, exp_v.vis, visible);
            n_errors++;
          end
          if (cull_plane !== exp_v.plane) begin
            $display("%0t: cull_plane mismatch: expected %0d actual %0d",
                     $time, exp_v.plane, cull_plane);
            n_errors++;
          end
          if (!exp_v.vis) n_culled++;
        end
        if (n_results == 150 && !long_hold_done) begin
          stall_cnt = 400;   // block fills and must stall its input
          long_hold_done = 1;
        end else begin
          stall_cnt = ((n_results / 200) % 4 == 1) ? 0 : $urandom_range(0, 8);
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, verdict_q.size());
      $display("[frustum_plane_extract_sphere_cull] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      proj_m[i] = 0;
      mv_m[i] = 0;
    end
    for (int i = 0; i < 24; i++) frustum_plane[i] = 0;
    build_stimulus();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !cmd_valid);
    wait (verdict_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("Run: %0d words, %0d extracts, %0d sphere results (%0d culled).",
             n_sent, n_extracts, n_results, n_culled);
    $display("Scenes: zero planes, random, perspective-like, saturating and zero matrices.");
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("[frustum_plane_extract_sphere_cull] OK");
    end else begin
      $display("[frustum_plane_extract_sphere_cull] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/fpesc_pkg.sv
rtl/frustum_plane_extract_sphere_cull.sv
rtl/fpesc_chk.sv
tb/testbench.sv
